/* rtl/pbl_pkg.sv */
// shared types, command codes and sizing constants for the positional byte list
package pbl_pkg;

	localparam int unsigned DefDepth = 64;

	typedef enum logic [3:0] {
		CMD_INSERT        = 4'd0,
		CMD_APPEND        = 4'd1,
		CMD_REMOVE_AT     = 4'd2,
		CMD_REMOVE_VALUE  = 4'd3,
		CMD_READ_AT       = 4'd4,
		CMD_INDEX_OF      = 4'd5,
		CMD_LAST          = 4'd6,
		CMD_CLEAR         = 4'd7,
		CMD_FIRST_SMALLER = 4'd8
	} pbl_cmd_e;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [3:0] command;
		logic [6:0] position;
		logic [7:0] value;
	} pbl_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic [5:0] found_position;
		logic [1:0] status;
		logic [6:0] entry_count;
	} pbl_rsp_t;

	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_LEFT  = 2'd1,
		OP_RIGHT = 2'd2,
		OP_LOAD  = 2'd3
	} pbl_op_e;

	typedef struct packed {
		logic    cmp_en;
		pbl_op_e op;
	} pbl_cell_ctl_t;

endpackage

/* rtl/pbl_cell.sv */
// one storage cell of the list row: holds a byte, shifts with neighbors, flags compares
module pbl_cell
	import pbl_pkg::*;
(
	input  logic          clk,
	input  pbl_cell_ctl_t ctl,
	input  logic [7:0]    left_entry,
	input  logic [7:0]    right_entry,
	input  logic [7:0]    new_entry,
	input  logic [7:0]    key,
	input  logic [7:0]    head,
	output logic [7:0]    entry_q,
	output logic          match_q,
	output logic          less_q
);

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			match_q <= (entry_q == key);
			less_q  <= (entry_q < head);
		end
		case (ctl.op)
			OP_LEFT:  entry_q <= left_entry;
			OP_RIGHT: entry_q <= right_entry;
			OP_LOAD:  entry_q <= new_entry;
			default:  entry_q <= entry_q;
		endcase
	end

endmodule

/* rtl/positional_byte_list_unit.sv */
// top level: a row of byte cells under a small sequencer, one reply per request
// sequence: one request at a time, busy while not idle; compare flags are registered in every cell,
// then the row shifts or is read in the next cycle, then the reply beat is out
// reset: arst_n clears the entry count, sequencer and reply strobe; cell bytes are not reset
module positional_byte_list_unit
	import pbl_pkg::*;
#(
	parameter int unsigned DEPTH = DefDepth
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pbl_req_t req,
	output logic     done,
	output pbl_rsp_t rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > 7) ? CW : 7;
	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FW = (IW > 6) ? IW : 6;

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC} state_t;

	state_t        state_q;
	pbl_req_t      req_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	pbl_rsp_t      rsp_q;

	logic [7:0]        entry [DEPTH];
	logic [DEPTH-1:0]  match_v;
	logic [DEPTH-1:0]  less_v;
	pbl_cell_ctl_t     ctl [DEPTH];

	logic [PW-1:0] pos_w, cnt_w, tgt_w, rd_w;
	logic          is_ins, ins_ok, rm_at_ok, is_exec;
	logic [DEPTH:0]   seen, later;
	logic [DEPTH-1:0] valid_v, first_v, pick_v;
	logic [FW-1:0]    fidx;
	logic [7:0]       rd_data, pick_data;

	logic [CW-1:0] cnt_nxt;
	pbl_rsp_t      rsp_nxt;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign is_exec = (state_q == S_EXEC);
	assign pos_w   = PW'(req_q.position);
	assign cnt_w   = PW'(cnt_q);
	assign is_ins  = (req_q.command == CMD_INSERT) || (req_q.command == CMD_APPEND);
	assign tgt_w   = (req_q.command == CMD_APPEND) ? cnt_w : pos_w;
	assign ins_ok  = is_ins && (tgt_w <= cnt_w) && (cnt_w < PW'(DEPTH));
	assign rm_at_ok = (req_q.command == CMD_REMOVE_AT) && (pos_w < cnt_w);
	assign rd_w    = (req_q.command == CMD_LAST) ? (cnt_w - PW'(1)) : pos_w;

	// first match runs up from the head, last smaller byte runs down from the tail
	assign seen[0]      = 1'b0;
	assign later[DEPTH] = 1'b0;

	genvar gi;
	for (gi = 0; gi < DEPTH; gi++) begin : g_row
		logic [7:0] left_e, right_e;

		assign valid_v[gi]  = (PW'(gi) < cnt_w);
		assign seen[gi+1]   = seen[gi] | (match_v[gi] & valid_v[gi]);
		assign first_v[gi]  = match_v[gi] & valid_v[gi] & ~seen[gi];
		assign later[gi]    = later[gi+1] | (less_v[gi] & valid_v[gi] & (gi != 0));
		assign pick_v[gi]   = less_v[gi] & valid_v[gi] & (gi != 0) & ~later[gi+1];

		if (gi == 0) begin : g_l0
			assign left_e = 8'd0;
		end else begin : g_ln
			assign left_e = entry[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_rl
			assign right_e = 8'd0;
		end else begin : g_rn
			assign right_e = entry[gi+1];
		end

		always_comb begin
			ctl[gi].cmp_en = (state_q == S_CMP);
			ctl[gi].op     = OP_HOLD;
			if (is_exec) begin
				if (ins_ok) begin
					if (PW'(gi) > tgt_w) begin
						ctl[gi].op = OP_LEFT;
					end else if (PW'(gi) == tgt_w) begin
						ctl[gi].op = OP_LOAD;
					end
				end else if (rm_at_ok && (PW'(gi) >= pos_w)) begin
					ctl[gi].op = OP_RIGHT;
				end else if ((req_q.command == CMD_REMOVE_VALUE) && seen[gi+1]) begin
					ctl[gi].op = OP_RIGHT;
				end
			end
		end

		pbl_cell u_cell (
			.clk         (clk),
			.ctl         (ctl[gi]),
			.left_entry  (left_e),
			.right_entry (right_e),
			.new_entry   (req_q.value),
			.key         (req_q.value),
			.head        (entry[0]),
			.entry_q     (entry[gi]),
			.match_q     (match_v[gi]),
			.less_q      (less_v[gi])
		);
	end

	// one-hot selections folded by or
	always_comb begin
		fidx      = '0;
		rd_data   = '0;
		pick_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_v[i]) fidx = fidx | FW'(i);
			if (PW'(i) == rd_w) rd_data = rd_data | entry[i];
			if (pick_v[i]) pick_data = pick_data | entry[i];
		end
	end

	always_comb begin
		logic [CW:0] cnt_x;
		logic [PW:0] cnt_o;
		cnt_x = '0;
		cnt_o = '0;
		rsp_nxt = '0;
		rsp_nxt.status = ST_OK;
		cnt_nxt = cnt_q;
		case (req_q.command)
			CMD_INSERT, CMD_APPEND: begin
				if (tgt_w > cnt_w) begin
					rsp_nxt.status = ST_NONE;
				end else if (!ins_ok) begin
					rsp_nxt.status = ST_FULL;
				end else begin
					cnt_nxt = cnt_q + CW'(1);
				end
			end
			CMD_REMOVE_AT: begin
				if (rm_at_ok) begin
					rsp_nxt.data = rd_data;
					cnt_nxt = cnt_q - CW'(1);
				end else begin
					rsp_nxt.status = ST_NONE;
				end
			end
			CMD_REMOVE_VALUE: begin
				if (seen[DEPTH]) begin
					rsp_nxt.data = req_q.value;
					cnt_nxt = cnt_q - CW'(1);
				end else begin
					rsp_nxt.status = ST_NONE;
				end
			end
			CMD_READ_AT: begin
				if (pos_w < cnt_w) rsp_nxt.data = rd_data;
				else rsp_nxt.status = ST_NONE;
			end
			CMD_INDEX_OF: begin
				if (seen[DEPTH]) rsp_nxt.found_position = fidx[5:0];
				else rsp_nxt.status = ST_NONE;
			end
			CMD_LAST: begin
				if (cnt_q != '0) rsp_nxt.data = rd_data;
				else rsp_nxt.status = ST_NONE;
			end
			CMD_CLEAR: begin
				cnt_nxt = '0;
			end
			CMD_FIRST_SMALLER: begin
				if (cnt_q == '0) rsp_nxt.status = ST_NONE;
				else if (later[0]) rsp_nxt.data = pick_data;
				else rsp_nxt.data = entry[0];
			end
			default: begin
				rsp_nxt.status = ST_NONE;
			end
		endcase
		cnt_x = {1'b0, cnt_nxt};
		cnt_o = (PW + 1)'(cnt_x);
		rsp_nxt.entry_count = cnt_o[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					cnt_q   <= cnt_nxt;
					rsp_q   <= rsp_nxt;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
